@@ rtl/takf_pkg.sv @@
// Package for the tilt angle Kalman filter unit: shared widths, reset values,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package takf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DtW = 24;
  localparam int unsigned QW = 24;
  localparam int unsigned RW = 28;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 28;

  localparam logic [CfgIdxW-1:0] CfgIdxDt = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxQ = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxR = 2'd2;

  localparam logic [DtW-1:0] DtReset = 24'd167772;
  localparam logic [QW-1:0] QReset = 24'd109555;
  localparam logic [RW-1:0] RReset = 28'd7164375;
  localparam logic signed [DataW-1:0] CovInit = 32'sd655360;

  // Divider: 64-bit magnitude quotient, one bit per cycle.
  localparam int unsigned DivSteps = 64;

  // Datapath micro-operations, one per controller step.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ANGLE_PRED,   // angle += round(dt*(rate-bias) >> 24)
    OP_DT_P11,       // t0 = dt*P11
    OP_INNER,        // inner = sat(round((t0 - (P01+P10)<<24 + q<<16) >> 24))
    OP_P00,          // p00 = sat(P00 + round(dt*inner >> 24))
    OP_P01_P10,      // p01, p10 from t0
    OP_P11,          // p11 = sat(P11 + round(dt*q >> 32))
    OP_S,            // s = p00*256 + r, diff
    OP_DIV0_START,
    OP_DIV0_END,
    OP_DIV1_START,
    OP_DIV1_END,
    OP_ANGLE_CORR,
    OP_BIAS_CORR,
    OP_BB_CORR,
    OP_BA_CORR,
    OP_AB_CORR,
    OP_AA_CORR
  } takf_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANGLE_PRED,
    ST_DT_P11,
    ST_INNER,
    ST_P00,
    ST_P01_P10,
    ST_P11,
    ST_S,
    ST_DIV0_START,
    ST_DIV0_WAIT,
    ST_DIV1_START,
    ST_DIV1_WAIT,
    ST_ANGLE_CORR,
    ST_BIAS_CORR,
    ST_BB_CORR,
    ST_BA_CORR,
    ST_AB_CORR,
    ST_AA_CORR,
    ST_OUT
  } takf_state_t;

  typedef struct packed {
    takf_op_t op;
    logic     load_in;
  } takf_cmd_t;

  typedef struct packed {
    logic div_done;
  } takf_status_t;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    begin
      hi = 66'sh0_7FFF_FFFF;
      lo = -66'sh0_8000_0000;
      if (v > hi) sat32 = 32'sh7FFF_FFFF;
      else if (v < lo) sat32 = 32'sh8000_0000;
      else sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

@@ rtl/tilt_angle_kalman_filter_unit.sv @@
// Tilt angle Kalman filter unit top level: configuration registers, stream
// ports, controller and datapath. Depends on takf_pkg, takf_ctrl, takf_dp.
//
// Each sample (acc_angle, gyro_rate) runs a predict and correct step of a
// two-state angle/bias Kalman filter in signed Q16.16 and returns one
// saturated angle estimate. After the accepting edge the unit runs 7
// sequenced predict steps, two gain divisions (each a start step, 64
// quotient bits and a finish step) through one bit-serial divider, and 6
// correction steps before the result is offered. The block holds one item
// at a time and accepts the next in the cycle after the result transaction.
module tilt_angle_kalman_filter_unit import takf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,   // [31:0] acc_angle, [63:32] gyro_rate
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [31:0] est_angle
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [DtW-1:0] dt_r;
  logic [QW-1:0]  q_r;
  logic [RW-1:0]  r_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DtReset;
      q_r <= QReset;
      r_r <= RReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgIdxDt: dt_r <= cfg_data[DtW-1:0];
        CfgIdxQ:  q_r <= cfg_data[QW-1:0];
        CfgIdxR:  r_r <= cfg_data[RW-1:0];
        default:  r_r <= r_r;
      endcase
    end
  end

  takf_cmd_t    cmd;
  takf_status_t status;
  logic         busy;
  logic         in_fire, out_fire;
  logic signed [DataW-1:0] est;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  takf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (out_tvalid)
  );

  takf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .acc_angle (in_tdata[31:0]),
    .gyro_rate (in_tdata[63:32]),
    .dt        (dt_r),
    .q         (q_r),
    .r         (r_r),
    .est_angle (est)
  );

  assign out_tdata = est;

  // The block never takes input while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input accepted while result pending");

  // A sample always starts work: no result in the cycle after acceptance.
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !out_tvalid && busy)
    else $error("controller did not start on accepted sample");

  // The estimate holds while the result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("estimate changed while stalled");

endmodule

@@ rtl/takf_ctrl.sv @@
// Controller for the tilt angle Kalman filter unit: sequences the predict,
// divide and correct steps. Depends on takf_pkg.
module takf_ctrl import takf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  input  logic         out_fire,
  input  takf_status_t status,
  output takf_cmd_t    cmd,
  output logic         busy,
  output logic         res_valid
);

  takf_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_fire) state_nxt = ST_ANGLE_PRED;
      ST_ANGLE_PRED: state_nxt = ST_DT_P11;
      ST_DT_P11:     state_nxt = ST_INNER;
      ST_INNER:      state_nxt = ST_P00;
      ST_P00:        state_nxt = ST_P01_P10;
      ST_P01_P10:    state_nxt = ST_P11;
      ST_P11:        state_nxt = ST_S;
      ST_S:          state_nxt = ST_DIV0_START;
      ST_DIV0_START: state_nxt = ST_DIV0_WAIT;
      ST_DIV0_WAIT:  if (status.div_done) state_nxt = ST_DIV1_START;
      ST_DIV1_START: state_nxt = ST_DIV1_WAIT;
      ST_DIV1_WAIT:  if (status.div_done) state_nxt = ST_ANGLE_CORR;
      ST_ANGLE_CORR: state_nxt = ST_BIAS_CORR;
      ST_BIAS_CORR:  state_nxt = ST_BB_CORR;
      ST_BB_CORR:    state_nxt = ST_BA_CORR;
      ST_BA_CORR:    state_nxt = ST_AB_CORR;
      ST_AB_CORR:    state_nxt = ST_AA_CORR;
      ST_AA_CORR:    state_nxt = ST_OUT;
      ST_OUT:        if (out_fire) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd.op = OP_NONE;
    cmd.load_in = 1'b0;
    busy = 1'b1;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load_in = in_fire;
      end
      ST_ANGLE_PRED: cmd.op = OP_ANGLE_PRED;
      ST_DT_P11:     cmd.op = OP_DT_P11;
      ST_INNER:      cmd.op = OP_INNER;
      ST_P00:        cmd.op = OP_P00;
      ST_P01_P10:    cmd.op = OP_P01_P10;
      ST_P11:        cmd.op = OP_P11;
      ST_S:          cmd.op = OP_S;
      ST_DIV0_START: cmd.op = OP_DIV0_START;
      ST_DIV0_WAIT:  if (status.div_done) cmd.op = OP_DIV0_END;
      ST_DIV1_START: cmd.op = OP_DIV1_START;
      ST_DIV1_WAIT:  if (status.div_done) cmd.op = OP_DIV1_END;
      ST_ANGLE_CORR: cmd.op = OP_ANGLE_CORR;
      ST_BIAS_CORR:  cmd.op = OP_BIAS_CORR;
      ST_BB_CORR:    cmd.op = OP_BB_CORR;
      ST_BA_CORR:    cmd.op = OP_BA_CORR;
      ST_AB_CORR:    cmd.op = OP_AB_CORR;
      ST_AA_CORR:    cmd.op = OP_AA_CORR;
      ST_OUT:        res_valid = 1'b1;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/takf_div.sv @@
// Restoring divider for the Kalman gains: 64-bit magnitude by 40-bit positive
// divisor, one quotient bit per cycle. Depends on takf_pkg.
module takf_div import takf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        num_mag,
  input  logic [39:0]        den,
  output logic               done,
  output logic [63:0]        quo
);

  logic [63:0] quo_r, quo_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [39:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [40:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial = {rem_r[39:0], quo_r[63]};
    if (start) begin
      quo_nxt = num_mag;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = 7'(DivSteps);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = !run_r && !start;
  assign quo = quo_r;

endmodule

@@ rtl/takf_dp.sv @@
// Datapath for the tilt angle Kalman filter unit: state, covariance, one
// shared 34x34 multiplier and the gain divider. Depends on takf_pkg, takf_div.
module takf_dp import takf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  takf_cmd_t               cmd,
  output takf_status_t            status,
  input  logic signed [DataW-1:0] acc_angle,
  input  logic signed [DataW-1:0] gyro_rate,
  input  logic [DtW-1:0]          dt,
  input  logic [QW-1:0]           q,
  input  logic [RW-1:0]           r,
  output logic signed [DataW-1:0] est_angle
);

  logic signed [DataW-1:0] angle_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [DataW-1:0] acc_r, rate_r;
  logic signed [DataW-1:0] inner_r, p00_r, p01_r, p10_r, p11_r, k0_r, k1_r;
  logic signed [65:0]      t0_r;
  logic signed [32:0]      diff_r;
  logic signed [40:0]      s_r;
  logic                    s_pos_r;
  logic                    neg_r;

  // Shared multiplier operands and product.
  logic signed [33:0] ma, mb;
  logic signed [65:0] prod;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_ANGLE_PRED: begin ma = 34'(signed'({1'b0, dt})); mb = 34'(rate_r) - 34'(bias_r); end
      OP_DT_P11:     begin ma = 34'(signed'({1'b0, dt})); mb = 34'(bb_r); end
      OP_P00:        begin ma = 34'(signed'({1'b0, dt})); mb = 34'(inner_r); end
      OP_P11:        begin ma = 34'(signed'({1'b0, dt})); mb = 34'(signed'({1'b0, q})); end
      OP_ANGLE_CORR: begin ma = 34'(k0_r); mb = 34'(diff_r); end
      OP_BIAS_CORR:  begin ma = 34'(k1_r); mb = 34'(diff_r); end
      OP_BB_CORR:    begin ma = 34'(k1_r); mb = 34'(p01_r); end
      OP_BA_CORR:    begin ma = 34'(k1_r); mb = 34'(p00_r); end
      OP_AB_CORR:    begin ma = 34'(k0_r); mb = 34'(p01_r); end
      OP_AA_CORR:    begin ma = 34'(k0_r); mb = 34'(p00_r); end
      default:       begin ma = '0; mb = '0; end
    endcase
    prod = 66'(ma) * 66'(mb);
  end

  // Round half up then arithmetic shift right by 24.
  function automatic logic signed [65:0] rnd24(input logic signed [65:0] v);
    logic signed [65:0] t;
    begin
      t = v + 66'sd8388608;
      rnd24 = t >>> 24;
    end
  endfunction

  function automatic logic signed [65:0] rnd32(input logic signed [65:0] v);
    logic signed [65:0] t;
    begin
      t = v + 66'sd2147483648;
      rnd32 = t >>> 32;
    end
  endfunction

  // Divider operand selection and sign handling.
  logic         div_start;
  logic [63:0]  div_num;
  logic         div_done;
  logic [63:0]  div_quo;
  logic signed [DataW-1:0] pdiv;
  logic signed [65:0] qsigned;
  logic signed [DataW-1:0] gain;

  assign pdiv = (cmd.op == OP_DIV1_START) ? p10_r : p00_r;
  assign div_start = (cmd.op == OP_DIV0_START) || (cmd.op == OP_DIV1_START);
  assign div_num = {(pdiv[DataW-1] ? 32'(-33'(pdiv)) : 32'(pdiv)), 32'd0};

  takf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (div_num),
    .den     (s_r[39:0]),
    .done    (div_done),
    .quo     (div_quo)
  );

  assign status.div_done = div_done;

  always_comb begin
    qsigned = neg_r ? -66'(signed'({2'b00, div_quo})) : 66'(signed'({2'b00, div_quo}));
    gain = s_pos_r ? sat32(qsigned) : '0;
  end

  // Register updates by operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r <= '0;
      aa_r <= CovInit;
      ab_r <= '0;
      ba_r <= '0;
      bb_r <= CovInit;
    end else begin
      case (cmd.op)
        OP_ANGLE_PRED: angle_r <= sat32(66'(angle_r) + rnd24(prod));
        OP_ANGLE_CORR: angle_r <= sat32(66'(angle_r) + rnd24(prod));
        OP_BIAS_CORR:  bias_r <= sat32(66'(bias_r) + rnd24(prod));
        OP_BB_CORR:    bb_r <= sat32(66'(p11_r) - rnd24(prod));
        OP_BA_CORR:    ba_r <= sat32(66'(p10_r) - rnd24(prod));
        OP_AB_CORR:    ab_r <= sat32(66'(p01_r) - rnd24(prod));
        OP_AA_CORR:    aa_r <= sat32(66'(p00_r) - rnd24(prod));
        default:       angle_r <= angle_r;
      endcase
    end
    if (cmd.load_in) begin
      acc_r <= acc_angle;
      rate_r <= gyro_rate;
    end
    case (cmd.op)
      OP_DT_P11: t0_r <= prod;
      OP_INNER: inner_r <= sat32(rnd24(t0_r - ((66'(ab_r) + 66'(ba_r)) <<< 24)
                                      + (66'(signed'({1'b0, q})) <<< 16)));
      OP_P00: p00_r <= sat32(66'(aa_r) + rnd24(prod));
      OP_P01_P10: begin
        p01_r <= sat32(66'(ab_r) - rnd24(t0_r));
        p10_r <= sat32(66'(ba_r) - rnd24(t0_r));
      end
      OP_P11: p11_r <= sat32(66'(bb_r) + rnd32(prod));
      OP_S: begin
        s_r <= (41'(p00_r) <<< 8) + 41'(signed'({1'b0, r}));
        s_pos_r <= ((41'(p00_r) <<< 8) + 41'(signed'({1'b0, r}))) > 41'sd0;
        diff_r <= 33'(acc_r) - 33'(angle_r);
      end
      OP_DIV0_START: neg_r <= p00_r[DataW-1];
      OP_DIV1_START: neg_r <= p10_r[DataW-1];
      OP_DIV0_END: k0_r <= gain;
      OP_DIV1_END: k1_r <= gain;
      default: t0_r <= t0_r;
    endcase
  end

  assign est_angle = angle_r;

endmodule
